FILE: rtl/core/ac3hp_pkg.sv
// ----------------------------------------------------------------------------
// ac3hp_pkg
// Shared types, constants and lookup tables for the AC-3 / E-AC-3 header
// parser pipeline.
// ----------------------------------------------------------------------------
package ac3hp_pkg;

  localparam int HdrW      = 56;
  localparam int PresW     = 3;
  localparam int TdataInW  = 64;
  localparam int TdataOutW = 96;
  localparam int BoxW      = 40;
  localparam int BpsW      = 23;
  localparam int RateW     = 16;
  localparam int ProdW     = 47;
  localparam int CapW      = 4;

  typedef enum logic [3:0] {
    ST_OK          = 4'd0,
    ST_SHORT       = 4'd1,
    ST_BAD_SYNC    = 4'd2,
    ST_BAD_BSID    = 4'd3,
    ST_BAD_FSCOD   = 4'd4,
    ST_BAD_FRMSIZE = 4'd5,
    ST_BAD_STRMTYP = 4'd6,
    ST_FRAME_SMALL = 4'd7,
    ST_BAD_FSCOD2  = 4'd8,
    ST_BOX_OVF     = 4'd9
  } status_t;

  localparam logic [PresW-1:0] HDR_BYTES       = 3'd7;
  localparam logic [15:0]      SYNC_WORD       = 16'h0B77;
  localparam logic [4:0]       BSID_AC3_MAX    = 5'd10;
  localparam logic [4:0]       BSID_MAX        = 5'd16;
  localparam logic [4:0]       BSID_SHIFT_BASE = 5'd8;
  localparam logic [4:0]       BRC_LIMIT       = 5'd19;
  localparam logic [1:0]       FSCOD_RESERVED  = 2'd3;
  localparam logic [1:0]       STRMTYP_RSVD    = 2'd3;
  localparam logic [1:0]       NUMBLK_SIX      = 2'd3;
  localparam logic [10:0]      FRMSIZ_MIN      = 11'd3;
  localparam logic [2:0]       DAC3_LEN        = 3'd3;
  localparam logic [2:0]       DEC3_LEN        = 3'd5;
  localparam logic [CapW-1:0]  CAP_RESET       = 4'd8;

  // floor(x/3) = (x * DIV3_MUL) >> DIV3_SHIFT for x < 2^23
  localparam logic [23:0] DIV3_MUL     = 24'd11184811;
  localparam int          DIV3_SHIFT   = 25;
  // floor(y/125) = (y * DIV125_MUL) >> DIV125_SHIFT for y < 2^20
  localparam logic [20:0] DIV125_MUL   = 21'd1073742;
  localparam int          DIV125_SHIFT = 27;

  typedef struct packed {
    status_t           status;
    logic              enh;
    logic [1:0]        fscod;
    logic [4:0]        bsid;
    logic [2:0]        bsmod;
    logic [2:0]        acmod;
    logic              lfe;
    logic [4:0]        brc;
    logic [RateW-1:0]  rate;
    logic [BpsW-1:0]   bps;
    logic [ProdW-1:0]  prod;
    logic              half;   // 2 or 6 blocks: extra divide by 2
    logic              div3;   // 3 or 6 blocks: divide by 3
  } item_t;

  function automatic logic [RateW-1:0] rate_of(input logic [1:0] code);
    logic [RateW-1:0] r;
    unique case (code)
      2'd0:    r = 16'd48000;
      2'd1:    r = 16'd44100;
      2'd2:    r = 16'd32000;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

  // AC-3 nominal bitrate in bit/s, indexed by frmsizecod / 2
  function automatic logic [19:0] ac3_bps(input logic [4:0] brc);
    logic [19:0] b;
    unique case (brc)
      5'd0:    b = 20'd32000;
      5'd1:    b = 20'd40000;
      5'd2:    b = 20'd48000;
      5'd3:    b = 20'd56000;
      5'd4:    b = 20'd64000;
      5'd5:    b = 20'd80000;
      5'd6:    b = 20'd96000;
      5'd7:    b = 20'd112000;
      5'd8:    b = 20'd128000;
      5'd9:    b = 20'd160000;
      5'd10:   b = 20'd192000;
      5'd11:   b = 20'd224000;
      5'd12:   b = 20'd256000;
      5'd13:   b = 20'd320000;
      5'd14:   b = 20'd384000;
      5'd15:   b = 20'd448000;
      5'd16:   b = 20'd512000;
      5'd17:   b = 20'd576000;
      5'd18:   b = 20'd640000;
      default: b = 20'd0;
    endcase
    return b;
  endfunction

  function automatic logic [2:0] chan_of(input logic [2:0] acmod);
    logic [2:0] c;
    unique case (acmod)
      3'd0:    c = 3'd2;
      3'd1:    c = 3'd1;
      3'd2:    c = 3'd2;
      3'd3:    c = 3'd3;
      3'd4:    c = 3'd3;
      3'd5:    c = 3'd4;
      3'd6:    c = 3'd4;
      default: c = 3'd5;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/core/ac3_eac3_header_parser_unit.sv
// ----------------------------------------------------------------------------
// ac3_eac3_header_parser_unit
// AC-3 / E-AC-3 sync frame header parser: sample rate, bitrate, channels and
// dac3/dec3 box from the first seven bytes of a frame.
// ----------------------------------------------------------------------------
// Usage:
//  - Input stream (in_*): one request per frame header, the seven leading
//    bytes plus a count of valid bytes. Output stream (out_*): one result per
//    request, in order, carrying status and the decoded fields.
//  - cfg_wr_en/cfg_wr_data set the box capacity in bytes (reset value 8);
//    write it only while no request is in flight.
//  - Pipeline: four register stages (decode, two divide stages, pack/output
//    register); each accepted request passes through them in that order.
//  - Throughput: one request per cycle unless out_tready stalls it. Every stage carries its own valid
//    bit; a stage loads whenever it is empty or its successor takes data.
//  - The widest steps are the 13x16 frame*rate product in decode and the
//    reciprocal multiplies (by 1/3, by 1/125) in the divide stages.
//  - Reset (rst_n low, synchronous) empties the pipeline and restores the
//    box capacity to 8.
//  - When out_tready is low the output register holds its result and the
//    stages behind it keep filling; in_tready drops only once all four
//    stages hold data. Nothing is dropped or duplicated.
// ----------------------------------------------------------------------------
module ac3_eac3_header_parser_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  // config
  input  logic                                cfg_wr_en,
  input  logic [ac3hp_pkg::CapW-1:0]          cfg_wr_data,   // box_capacity
  // request stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [55:0] header_bytes, [58:56] bytes_present, [63:59] zero
  input  logic [ac3hp_pkg::TdataInW-1:0]      in_tdata,
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [3:0] status, [4] is_enhanced, [27:5] bit_rate, [43:28] rate_hz,
  // [46:44] channel_count, [49:47] audio_coding_mode, [50] lfe_present,
  // [90:51] box_data, [93:91] box_length, [95:94] zero
  output logic [ac3hp_pkg::TdataOutW-1:0]     out_tdata
);

  logic [ac3hp_pkg::CapW-1:0] cap_r;

  logic             dec_valid;
  logic             dec_ready;
  ac3hp_pkg::item_t dec_item;
  logic             div_valid;
  logic             div_ready;
  ac3hp_pkg::item_t div_item;

  // box capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= ac3hp_pkg::CAP_RESET;
    end else if (cfg_wr_en) begin
      cap_r <= cfg_wr_data;
    end
  end

  // stage 1: header checks and field decode
  ac3hp_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_valid   (in_tvalid),
    .s_ready   (in_tready),
    .s_hdr     (in_tdata[ac3hp_pkg::HdrW-1:0]),
    .s_present (in_tdata[ac3hp_pkg::HdrW+ac3hp_pkg::PresW-1:ac3hp_pkg::HdrW]),
    .m_valid   (dec_valid),
    .m_ready   (dec_ready),
    .m_item    (dec_item)
  );

  // stages 2-3: E-AC-3 bitrate division and kbit/s for the box
  ac3hp_divide u_divide (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (dec_valid),
    .s_ready (dec_ready),
    .s_item  (dec_item),
    .m_valid (div_valid),
    .m_ready (div_ready),
    .m_item  (div_item)
  );

  // stage 4: box build, capacity check, output register
  ac3hp_pack u_pack (
    .clk     (clk),
    .rst_n   (rst_n),
    .cap     (cap_r),
    .s_valid (div_valid),
    .s_ready (div_ready),
    .s_item  (div_item),
    .m_valid (out_tvalid),
    .m_ready (out_tready),
    .m_data  (out_tdata)
  );

endmodule

FILE: rtl/core/ac3hp_decode.sv
// ----------------------------------------------------------------------------
// ac3hp_decode
// Stage 1: sync/bsid checks, field extraction for both paths, AC-3 rates,
// E-AC-3 frame size times sample rate product.
// ----------------------------------------------------------------------------
module ac3hp_decode (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        s_valid,
  output logic                        s_ready,
  input  logic [ac3hp_pkg::HdrW-1:0]  s_hdr,
  input  logic [ac3hp_pkg::PresW-1:0] s_present,
  output logic                        m_valid,
  input  logic                        m_ready,
  output ac3hp_pkg::item_t            m_item
);

  logic             valid_r;
  ac3hp_pkg::item_t item_r;
  ac3hp_pkg::item_t item_nxt;

  logic [4:0]  bsid;
  logic [1:0]  fscod;
  logic [1:0]  fscod2;
  logic [1:0]  strmtyp;
  logic [10:0] frmsiz;
  logic [1:0]  shift;
  logic        ac3_lfe;
  logic [11:0] frm_words;
  logic [12:0] frame;
  logic [1:0]  numblk;
  logic [ac3hp_pkg::RateW-1:0] eac3_rate;
  logic [28:0] frame_rate;

  assign bsid    = s_hdr[15:11];
  assign fscod   = s_hdr[23:22];
  assign fscod2  = s_hdr[21:20];
  assign strmtyp = s_hdr[39:38];
  assign frmsiz  = s_hdr[34:24];

  // bsid 9 and 10 halve / quarter the AC-3 rates
  assign shift = (bsid > ac3hp_pkg::BSID_SHIFT_BASE) ?
                 2'(bsid - ac3hp_pkg::BSID_SHIFT_BASE) : 2'd0;

  // lfeon position depends on which optional mix fields are present
  always_comb begin
    unique case (s_hdr[7:5]) inside
      3'd0, 3'd1: ac3_lfe = s_hdr[4];
      3'd5, 3'd7: ac3_lfe = s_hdr[0];
      default:    ac3_lfe = s_hdr[2];
    endcase
  end

  assign frm_words  = {1'b0, frmsiz} + 12'd1;
  assign frame      = {frm_words, 1'b0};
  assign numblk     = (fscod == ac3hp_pkg::FSCOD_RESERVED) ? ac3hp_pkg::NUMBLK_SIX
                                                           : s_hdr[21:20];
  assign eac3_rate  = (fscod == ac3hp_pkg::FSCOD_RESERVED) ?
                      (ac3hp_pkg::rate_of(fscod2) >> 1) : ac3hp_pkg::rate_of(fscod);
  assign frame_rate = {16'd0, frame} * {13'd0, eac3_rate};

  always_comb begin
    item_nxt        = '0;
    item_nxt.status = ac3hp_pkg::ST_OK;
    item_nxt.fscod  = fscod;
    item_nxt.bsid   = bsid;
    if (s_present < ac3hp_pkg::HDR_BYTES) begin
      item_nxt.status = ac3hp_pkg::ST_SHORT;
    end else if (s_hdr[55:40] != ac3hp_pkg::SYNC_WORD) begin
      item_nxt.status = ac3hp_pkg::ST_BAD_SYNC;
    end else if (bsid > ac3hp_pkg::BSID_MAX) begin
      item_nxt.status = ac3hp_pkg::ST_BAD_BSID;
    end else if (bsid <= ac3hp_pkg::BSID_AC3_MAX) begin
      item_nxt.brc   = s_hdr[21:17];
      item_nxt.bsmod = s_hdr[10:8];
      item_nxt.acmod = s_hdr[7:5];
      item_nxt.lfe   = ac3_lfe;
      item_nxt.rate  = ac3hp_pkg::rate_of(fscod) >> shift;
      item_nxt.bps   = {3'b000, ac3hp_pkg::ac3_bps(s_hdr[21:17]) >> shift};
      if (fscod == ac3hp_pkg::FSCOD_RESERVED) begin
        item_nxt.status = ac3hp_pkg::ST_BAD_FSCOD;
      end else if (s_hdr[21:17] >= ac3hp_pkg::BRC_LIMIT) begin
        item_nxt.status = ac3hp_pkg::ST_BAD_FRMSIZE;
      end
    end else begin
      item_nxt.enh   = 1'b1;
      item_nxt.acmod = s_hdr[19:17];
      item_nxt.lfe   = s_hdr[16];
      item_nxt.rate  = eac3_rate;
      item_nxt.prod  = {18'd0, frame_rate};
      item_nxt.half  = numblk[0];
      item_nxt.div3  = numblk[1];
      if (strmtyp == ac3hp_pkg::STRMTYP_RSVD) begin
        item_nxt.status = ac3hp_pkg::ST_BAD_STRMTYP;
      end else if (frmsiz < ac3hp_pkg::FRMSIZ_MIN) begin
        item_nxt.status = ac3hp_pkg::ST_FRAME_SMALL;
      end else if (fscod == ac3hp_pkg::FSCOD_RESERVED &&
                   fscod2 == ac3hp_pkg::FSCOD_RESERVED) begin
        item_nxt.status = ac3hp_pkg::ST_BAD_FSCOD2;
      end
    end
  end

  assign s_ready = !valid_r || m_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (s_ready) begin
      valid_r <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_ready && s_valid) begin
      item_r <= item_nxt;
    end
  end

  assign m_valid = valid_r;
  assign m_item  = item_r;

endmodule

FILE: rtl/core/ac3hp_divide.sv
// ----------------------------------------------------------------------------
// ac3hp_divide
// Stages 2 and 3: E-AC-3 bitrate = frame*rate / (32*blocks) by shift and
// reciprocal multiply, then the kbit/s quotient for the dec3 box.
// ----------------------------------------------------------------------------
module ac3hp_divide (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             s_valid,
  output logic             s_ready,
  input  ac3hp_pkg::item_t s_item,
  output logic             m_valid,
  input  logic             m_ready,
  output ac3hp_pkg::item_t m_item
);

  logic             a_valid_r;
  logic             b_valid_r;
  logic             a_ready;
  logic             b_ready;
  ac3hp_pkg::item_t a_r;
  ac3hp_pkg::item_t a_nxt;
  ac3hp_pkg::item_t b_r;
  ac3hp_pkg::item_t b_nxt;

  logic [ac3hp_pkg::BpsW-1:0]  scaled;
  logic [ac3hp_pkg::BpsW-1:0]  quot;
  logic [40:0]                 kprod;

  // stage A: divide by 32 or 64, start the divide by 3
  assign scaled = !s_item.enh ? s_item.bps :
                  (s_item.half ? s_item.prod[28:6] : s_item.prod[27:5]);

  always_comb begin
    a_nxt      = s_item;
    a_nxt.bps  = scaled;
    a_nxt.prod = {24'd0, scaled} * {23'd0, ac3hp_pkg::DIV3_MUL};
  end

  // stage B: finish divide by 3, start bit/s -> kbit/s
  assign quot  = (a_r.enh && a_r.div3) ?
                 {1'b0, a_r.prod[ac3hp_pkg::ProdW-1:ac3hp_pkg::DIV3_SHIFT]} : a_r.bps;
  assign kprod = {21'd0, quot[ac3hp_pkg::BpsW-1:3]} * {20'd0, ac3hp_pkg::DIV125_MUL};

  always_comb begin
    b_nxt      = a_r;
    b_nxt.bps  = quot;
    b_nxt.prod = {6'd0, kprod};
  end

  assign b_ready = !b_valid_r || m_ready;
  assign a_ready = !a_valid_r || b_ready;
  assign s_ready = a_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_r <= s_valid;
      end
      if (b_ready) begin
        b_valid_r <= a_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && s_valid) begin
      a_r <= a_nxt;
    end
    if (b_ready && a_valid_r) begin
      b_r <= b_nxt;
    end
  end

  assign m_valid = b_valid_r;
  assign m_item  = b_r;

endmodule

FILE: rtl/core/ac3hp_pack.sv
// ----------------------------------------------------------------------------
// ac3hp_pack
// Stage 4: dac3/dec3 box assembly, capacity check, zeroing on error and the
// output register.
// ----------------------------------------------------------------------------
module ac3hp_pack (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [ac3hp_pkg::CapW-1:0]       cap,
  input  logic                             s_valid,
  output logic                             s_ready,
  input  ac3hp_pkg::item_t                 s_item,
  output logic                             m_valid,
  input  logic                             m_ready,
  output logic [ac3hp_pkg::TdataOutW-1:0]  m_data
);

  logic                                valid_r;
  logic [ac3hp_pkg::TdataOutW-1:0]     data_r;
  logic [ac3hp_pkg::TdataOutW-1:0]     data_nxt;

  logic [12:0]                 kbps;
  logic [ac3hp_pkg::BoxW-1:0]  box;
  logic [2:0]                  blen;
  logic [2:0]                  chans;
  ac3hp_pkg::status_t          status;

  assign kbps = s_item.prod[ac3hp_pkg::DIV125_SHIFT+12:ac3hp_pkg::DIV125_SHIFT];

  always_comb begin
    if (s_item.enh) begin
      box  = {kbps, 3'b000, s_item.fscod, s_item.bsid, 5'b00000,
              s_item.acmod, s_item.lfe, 8'h00};
      blen = ac3hp_pkg::DEC3_LEN;
    end else begin
      box  = {s_item.fscod, s_item.bsid, s_item.bsmod, s_item.acmod,
              s_item.lfe, s_item.brc, 5'b00000, 16'h0000};
      blen = ac3hp_pkg::DAC3_LEN;
    end
  end

  assign chans = ac3hp_pkg::chan_of(s_item.acmod) + {2'b00, s_item.lfe};

  always_comb begin
    status = s_item.status;
    if (s_item.status == ac3hp_pkg::ST_OK && {1'b0, cap} < {2'b00, blen}) begin
      status = ac3hp_pkg::ST_BOX_OVF;
    end
  end

  always_comb begin
    data_nxt      = '0;
    data_nxt[3:0] = status;
    data_nxt[4]   = s_item.enh;
    if (status == ac3hp_pkg::ST_OK) begin
      data_nxt[27:5]  = s_item.bps;
      data_nxt[43:28] = s_item.rate;
      data_nxt[46:44] = chans;
      data_nxt[49:47] = s_item.acmod;
      data_nxt[50]    = s_item.lfe;
      data_nxt[90:51] = box;
      data_nxt[93:91] = blen;
    end
  end

  assign s_ready = !valid_r || m_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (s_ready) begin
      valid_r <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_ready && s_valid) begin
      data_r <= data_nxt;
    end
  end

  assign m_valid = valid_r;
  assign m_data  = data_r;

endmodule
